// ----- hw/rtl/wve_pkg.sv -----
// Shared constants and widths for the window velocity estimator.
// Used by wve_mul, wve_div and window_velocity_estimator_top; no dependencies.
`timescale 1ns / 1ps

package wve_pkg;

   localparam int WINDOW = 8;
   localparam int WB     = $clog2(WINDOW);
   localparam int HALF   = WINDOW / 2;

   // Exact sum widths: sums of d and altitude, sums of 64-bit products,
   // and the trapezoid accumulator.
   localparam int SD_W   = 33 + WB;
   localparam int SAD_W  = 65 + WB;
   localparam int ACC_W  = 67 + WB;
   localparam int NUM_W  = 2 * SD_W;
   localparam int PROD_W = NUM_W + SD_W;

   localparam int CNT_W  = $clog2(WINDOW + 4);

   localparam int REQ_W  = 96;
   localparam int RSP_W  = 104;

   localparam logic [1:0] REG_TPS = 2'd0;
   localparam logic [1:0] REG_MAX = 2'd1;
   localparam logic [1:0] REG_MIN = 2'd2;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_UNDEF = 2'd1;
   localparam logic [1:0] ERR_RANGE = 2'd2;

endpackage

// ----- hw/rtl/wve_mul.sv -----
// Bit-serial signed multiplier, one multiplier bit per cycle.
// Depends on wve_pkg for operand and product widths.
`timescale 1ns / 1ps

module wve_mul (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [wve_pkg::NUM_W-1:0] a,
   input  logic signed [wve_pkg::SD_W-1:0]  b,
   output logic                             busy,
   output logic signed [wve_pkg::PROD_W-1:0] product
);

   localparam int MC_W = $clog2(wve_pkg::SD_W);

   logic                              busy_ff;
   logic [MC_W-1:0]                   cnt_ff;
   logic signed [wve_pkg::PROD_W-1:0] acc_ff;
   logic signed [wve_pkg::PROD_W-1:0] mcand_ff;
   logic [wve_pkg::SD_W-1:0]          mplier_ff;
   logic                              last;

   assign last = (cnt_ff == MC_W'(wve_pkg::SD_W - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff    <= '0;
         mcand_ff  <= wve_pkg::PROD_W'(a);
         mplier_ff <= b;
      end else if (busy_ff) begin
         // The top bit of the multiplier carries negative weight.
         if (mplier_ff[0]) begin
            if (last) begin
               acc_ff <= acc_ff - mcand_ff;
            end else begin
               acc_ff <= acc_ff + mcand_ff;
            end
         end
         mcand_ff  <= mcand_ff <<< 1;
         mplier_ff <= mplier_ff >> 1;
      end
   end

   assign busy    = busy_ff;
   assign product = acc_ff;

endmodule

// ----- hw/rtl/wve_div.sv -----
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on wve_pkg for the operand width.
`timescale 1ns / 1ps

module wve_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [wve_pkg::PROD_W-1:0] dividend,
   input  logic signed [wve_pkg::PROD_W-1:0] divisor,
   output logic                              busy,
   output logic signed [wve_pkg::PROD_W-1:0] quotient
);

   localparam int W    = wve_pkg::PROD_W;
   localparam int DC_W = $clog2(W + 1);

   logic            busy_ff;
   logic [DC_W-1:0] cnt_ff;
   logic            neg_ff;
   logic [W:0]      rem_ff;
   logic [W-1:0]    num_ff;
   logic [W-1:0]    den_ff;
   logic [W:0]      rem_sh;
   logic            fits;
   logic            fix;

   assign rem_sh = {rem_ff[W-1:0], num_ff[W-1]};
   assign fits   = (rem_sh >= {1'b0, den_ff});
   assign fix    = (cnt_ff == DC_W'(W));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (fix) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[W-1] ^ divisor[W-1];
         rem_ff <= '0;
         num_ff <= dividend[W-1] ? W'(-dividend) : W'(dividend);
         den_ff <= divisor[W-1] ? W'(-divisor) : W'(divisor);
      end else if (busy_ff) begin
         if (fix) begin
            // Apply the sign once all magnitude bits are in.
            num_ff <= neg_ff ? W'(-num_ff) : num_ff;
         end else begin
            rem_ff <= fits ? (rem_sh - {1'b0, den_ff}) : rem_sh;
            num_ff <= {num_ff[W-2:0], fits};
         end
      end
   end

   assign busy     = busy_ff;
   assign quotient = num_ff;

endmodule

// ----- hw/rtl/window_velocity_estimator_top.sv -----
// Top level of the window velocity estimator: sample window memory, sum pipeline,
// sequencer and output register. Depends on wve_pkg, wve_mul and wve_div.
`timescale 1ns / 1ps

//  Channel | Direction | Handshake             | Content
//  req_    | in        | req_tvalid/req_tready | one sample item
//  rsp_    | out       | rsp_tvalid/rsp_tready | one velocity result item
//  csr_    | in        | csr_we                | register write, no read-back
//
// Each item walks the window memory, then the bit-serial divider runs twice;
// the first pass overlaps the two serial multiplies, and the second follows
// the second multiply and is skipped when the denominator is zero. A new item
// is taken only in the idle state. Reset is synchronous and clears the window
// valid bits, so the window reads as all zero without a clearing pass. A result
// that waits in the output register does not hold up the next item until that
// item's result is ready to be loaded.

module window_velocity_estimator_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // altitude [31:0], acceleration [63:32], timestamp [95:64]
   input  logic [wve_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // velocity [31:0], slope_term [63:32], integral_term [95:64],
   // error_code [97:96], zero fill [103:98]
   output logic [wve_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [31:0]                 csr_wdata
);

   localparam int WB     = wve_pkg::WB;
   localparam int CNT_W  = wve_pkg::CNT_W;
   localparam int SD_W   = wve_pkg::SD_W;
   localparam int SAD_W  = wve_pkg::SAD_W;
   localparam int ACC_W  = wve_pkg::ACC_W;
   localparam int NUM_W  = wve_pkg::NUM_W;
   localparam int PROD_W = wve_pkg::PROD_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOOP = 3'd1;
   localparam logic [2:0] S_MUL1 = 3'd2;
   localparam logic [2:0] S_FORM = 3'd3;
   localparam logic [2:0] S_MUL2 = 3'd4;
   localparam logic [2:0] S_DIV  = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;

   localparam logic signed [NUM_W-1:0] N_C = NUM_W'(wve_pkg::WINDOW);

   // Configuration registers.
   logic [31:0]        tps_ff;
   logic signed [31:0] max_ff;
   logic signed [31:0] min_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= 32'd100000;
         max_ff <= 32'sd26214400;
         min_ff <= -32'sd26214400;
      end else if (csr_we) begin
         unique case (csr_index)
            wve_pkg::REG_TPS: tps_ff <= csr_wdata;
            wve_pkg::REG_MAX: max_ff <= csr_wdata;
            wve_pkg::REG_MIN: min_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A zero tick rate counts as one tick per second.
   logic [31:0] tps_eff;
   assign tps_eff = (tps_ff == 32'd0) ? 32'd1 : tps_ff;

   // Sequencer state.
   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WB-1:0]    wp_ff, wp_in;
   logic             accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // The window memory holds one sample per entry; the newest sits at wp_ff
   // and older samples at lower addresses, wrapping around.
   logic [wve_pkg::REQ_W-1:0] mem [wve_pkg::WINDOW];
   logic [wve_pkg::WINDOW-1:0] vld_ff;
   logic [wve_pkg::REQ_W-1:0] mem_rd_ff;
   logic                      rd_vld_ff;
   logic                      rd_go;
   logic [WB:0]               rd_sum;
   logic [WB-1:0]             rd_addr;
   logic [31:0]               t0_ff;

   assign wp_in = (wp_ff == WB'(wve_pkg::WINDOW - 1)) ? '0 : wp_ff + 1'b1;
   assign rd_go = (state_ff == S_LOOP) && (cnt_ff < CNT_W'(wve_pkg::WINDOW));

   always_comb begin
      if ({1'b0, wp_ff} >= (WB + 1)'(cnt_ff)) begin
         rd_sum = {1'b0, wp_ff} - (WB + 1)'(cnt_ff);
      end else begin
         rd_sum = {1'b0, wp_ff} + (WB + 1)'(wve_pkg::WINDOW) - (WB + 1)'(cnt_ff);
      end
      rd_addr = rd_sum[WB-1:0];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mem[wp_in] <= req_tdata;
      end
      if (rd_go) begin
         mem_rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         wp_ff  <= '0;
      end else if (accept) begin
         vld_ff[wp_in] <= 1'b1;
         wp_ff         <= wp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         t0_ff <= req_tdata[95:64];
      end
      if (rd_go) begin
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   // Sum pipeline: memory read, relative time, products, accumulation.
   logic                     go0_ff, go1_ff, go2_ff;
   logic [CNT_W-1:0]         idx0_ff, idx1_ff;
   logic [wve_pkg::REQ_W-1:0] word0;
   logic signed [31:0]       d1_ff, a1_ff, c1_ff, dp_ff, cp_ff;
   logic signed [63:0]       pad_ff, pdd_ff;
   logic signed [65:0]       pint_ff;
   logic                     ien2_ff;
   logic signed [32:0]       asum, dsub;
   logic                     ien1;
   logic signed [SD_W-1:0]   sd_ff, sa_ff;
   logic signed [SAD_W-1:0]  sad_ff, sdd_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   assign word0 = rd_vld_ff ? mem_rd_ff : '0;
   assign asum  = 33'(c1_ff) + 33'(cp_ff);
   assign dsub  = 33'(dp_ff) - 33'(d1_ff);
   assign ien1  = (idx1_ff >= CNT_W'(1)) && (idx1_ff <= CNT_W'(wve_pkg::HALF + 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         go0_ff <= 1'b0;
         go1_ff <= 1'b0;
         go2_ff <= 1'b0;
      end else begin
         go0_ff <= rd_go;
         go1_ff <= go0_ff;
         go2_ff <= go1_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx0_ff <= cnt_ff;
      if (go0_ff) begin
         idx1_ff <= idx0_ff;
         d1_ff   <= word0[95:64] - t0_ff;
         a1_ff   <= word0[31:0];
         c1_ff   <= word0[63:32];
         dp_ff   <= d1_ff;
         cp_ff   <= c1_ff;
      end
      if (go1_ff) begin
         pad_ff  <= a1_ff * d1_ff;
         pdd_ff  <= d1_ff * d1_ff;
         pint_ff <= asum * dsub;
         ien2_ff <= ien1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sd_ff  <= '0;
         sa_ff  <= '0;
         sad_ff <= '0;
         sdd_ff <= '0;
         acc_ff <= '0;
      end else begin
         if (go1_ff) begin
            sd_ff <= sd_ff + SD_W'(d1_ff);
            sa_ff <= sa_ff + SD_W'(a1_ff);
         end
         if (go2_ff) begin
            sad_ff <= sad_ff + SAD_W'(pad_ff);
            sdd_ff <= sdd_ff + SAD_W'(pdd_ff);
            if (ien2_ff) begin
               acc_ff <= acc_ff + ACC_W'(pint_ff);
            end
         end
      end
   end

   // Arithmetic units.
   logic                     loop_end;
   logic                     mul0_start, mul1_start, div_start;
   logic signed [NUM_W-1:0]  mul0_a;
   logic signed [SD_W-1:0]   mul0_b;
   logic                     mul0_busy, mul1_busy, div_busy;
   logic signed [PROD_W-1:0] mul0_p, mul1_p, div_q;
   logic signed [PROD_W-1:0] div_n, div_d;
   logic signed [NUM_W-1:0]  numer_ff, denom_ff;
   logic signed [PROD_W-1:0] integ_ff;

   assign loop_end   = (state_ff == S_LOOP) && (cnt_ff == CNT_W'(wve_pkg::WINDOW + 3));
   assign mul0_start = loop_end || (state_ff == S_FORM);
   assign mul1_start = loop_end;
   assign mul0_a     = (state_ff == S_FORM) ? numer_ff : NUM_W'(sd_ff);
   assign mul0_b     = (state_ff == S_FORM) ? SD_W'({1'b0, tps_eff}) : sa_ff;

   assign div_start = loop_end ||
                      ((state_ff == S_MUL2) && !mul0_busy && !div_busy &&
                       (denom_ff != '0));
   assign div_n = (state_ff == S_MUL2) ? mul0_p : PROD_W'(acc_ff);
   assign div_d = (state_ff == S_MUL2) ? PROD_W'(denom_ff) :
                                         PROD_W'({1'b0, tps_eff, 1'b0});

   wve_mul u_mul0 (
      .clock   (clock),
      .reset   (reset),
      .start   (mul0_start),
      .a       (mul0_a),
      .b       (mul0_b),
      .busy    (mul0_busy),
      .product (mul0_p)
   );

   wve_mul u_mul1 (
      .clock   (clock),
      .reset   (reset),
      .start   (mul1_start),
      .a       (NUM_W'(sd_ff)),
      .b       (sd_ff),
      .busy    (mul1_busy),
      .product (mul1_p)
   );

   wve_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .busy     (div_busy),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if ((state_ff == S_MUL1) && !mul0_busy && !mul1_busy) begin
         numer_ff <= NUM_W'(mul0_p) - N_C * NUM_W'(sad_ff);
         denom_ff <= NUM_W'(mul1_p) - N_C * NUM_W'(sdd_ff);
      end
      if ((state_ff == S_MUL2) && !mul0_busy && !div_busy) begin
         integ_ff <= div_q;
      end
   end

   // Final result forming.
   logic                     denom_zero;
   logic signed [PROD_W-1:0] slope_q;
   logic signed [PROD_W:0]   vel;
   logic [1:0]               err;
   logic [31:0]              vel_o, slope_o, integ_o;
   logic                     out_free;
   logic                     rsp_tvalid_ff;
   logic [wve_pkg::RSP_W-1:0] rsp_data_ff;

   function automatic logic [31:0] sat32(input logic signed [PROD_W-1:0] x);
      logic [31:0] r;
      if ((x[PROD_W-1:31] == '0) || (x[PROD_W-1:31] == '1)) begin
         r = x[31:0];
      end else begin
         r = x[PROD_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      return r;
   endfunction

   assign denom_zero = (denom_ff == '0);
   assign slope_q    = denom_zero ? '0 : div_q;
   assign vel        = (PROD_W + 1)'(slope_q) + (PROD_W + 1)'(integ_ff);

   always_comb begin
      if (denom_zero) begin
         err = (numer_ff == '0) ? wve_pkg::ERR_UNDEF : wve_pkg::ERR_RANGE;
      end else if ((vel > (PROD_W + 1)'(max_ff)) || (vel < (PROD_W + 1)'(min_ff))) begin
         err = wve_pkg::ERR_RANGE;
      end else begin
         err = wve_pkg::ERR_NONE;
      end
      vel_o   = (err == wve_pkg::ERR_NONE) ? vel[31:0] : 32'd0;
      slope_o = sat32(slope_q);
      integ_o = sat32(integ_ff);
   end

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if ((state_ff == S_FIN) && out_free) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_FIN) && out_free) begin
         rsp_data_ff <= {6'd0, err, integ_o, slope_o, vel_o};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOOP;
               cnt_in   = '0;
            end
         end
         S_LOOP: begin
            cnt_in = cnt_ff + 1'b1;
            if (loop_end) begin
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            if (!mul0_busy && !mul1_busy) begin
               state_in = S_FORM;
            end
         end
         S_FORM: begin
            state_in = S_MUL2;
         end
         S_MUL2: begin
            if (!mul0_busy && !div_busy) begin
               state_in = (denom_ff != '0) ? S_DIV : S_FIN;
            end
         end
         S_DIV: begin
            if (!div_busy) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
